/* hdl/msog_pkg.sv */
// Shared types, constants and helper functions for the matrix scan order generator.
// No dependencies; imported by matrix_scan_order_generator_top.
package msog_pkg;

  // Largest grid side supported
  localparam int MAX_SIDE = 64;

  // Field widths
  localparam int SIDE_W  = 7;
  localparam int ROW_W   = 6;
  localparam int ORDER_W = 13;
  localparam int DIR_W   = 2;
  localparam int IDX_W   = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_IDX_SIDE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IDX_MODE = 2'd1;

  // Reset side length
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;

  typedef enum logic [1:0] {
    MODE_COLUMN     = 2'd0,
    MODE_SERPENTINE = 2'd1,
    MODE_ZIGZAG     = 2'd2,
    MODE_SPIRAL     = 2'd3
  } scan_mode_t;

  // Spiral walking directions
  typedef enum logic [DIR_W-1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } spiral_dir_t;

  // Diagonal walking directions for the zigzag
  localparam logic [DIR_W-1:0] DIAG_UP_LEFT    = 2'd0;
  localparam logic [DIR_W-1:0] DIAG_DOWN_RIGHT = 2'd1;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic [ORDER_W-1:0] count;
    logic [DIR_W-1:0]   dir;
    logic [ROW_W-1:0]   top;
    logic [ROW_W-1:0]   bottom;
    logic [ROW_W-1:0]   left;
    logic [ROW_W-1:0]   right;
  } scan_state_t;

  // Force a written side into 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] res;
    if (v == '0) begin
      res = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      res = SIDE_W'(MAX_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // State at the first cell of a scan
  function automatic scan_state_t start_state(logic [SIDE_W-1:0] side, scan_mode_t mode);
    scan_state_t s;
    logic [SIDE_W-1:0] last_idx;
    last_idx = side - SIDE_W'(1);
    s.count  = '0;
    s.dir    = '0;
    s.top    = '0;
    s.bottom = last_idx[ROW_W-1:0];
    s.left   = '0;
    s.right  = last_idx[ROW_W-1:0];
    s.col    = '0;
    s.row    = (mode == MODE_ZIGZAG) ? last_idx[ROW_W-1:0] : '0;
    return s;
  endfunction

endpackage

/* hdl/matrix_scan_order_generator_top.sv */
// Top level of the matrix scan order generator: scan state, step logic and output register.
// Depends on msog_pkg for widths, codes and the scan state type.

// The block emits one grid cell per accepted input transfer, one transfer per clock:
// the next cell is worked out by a single level of compare and increment logic between
// the scan state registers and the output register, so an item enters every cycle
// while the output side keeps up. The result appears in the cycle after its input
// transfer. A set restart bit emits the first cell of the scan; after the cell with
// tlast set the scan wraps to its first cell. Writing either configuration register
// (side, scan mode) also restarts the scan; a side of 0 is taken as 1 and one above 64
// as 64. The order is 1-based and equals side * side on the last cell.
module matrix_scan_order_generator_top
  import msog_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [5:0] row, [11:6] col, [24:12] order, [31:25] zero
  output logic                 out_tlast   // last cell of the scan
);

  logic [SIDE_W-1:0]  side_r, side_nxt;
  scan_mode_t         mode_r, mode_nxt;
  scan_state_t        st_r, st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [ROW_W-1:0]   out_col_r, out_col_nxt;
  logic [ORDER_W-1:0] out_order_r, out_order_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               restart;
  scan_state_t        cur;
  scan_state_t        adv;
  logic [ROW_W-1:0]   last_idx;
  logic [ORDER_W-1:0] total;
  logic [ORDER_W-1:0] order;
  logic               is_last;

  // zigzag diagonal arithmetic, two bits wider than a coordinate
  logic signed [ROW_W+1:0] diag;
  logic signed [ROW_W+1:0] diag_m1;
  logic signed [ROW_W+1:0] side_m1;
  logic signed [ROW_W+1:0] diag_tmp;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  assign last_idx = ROW_W'(side_r - SIDE_W'(1));
  assign total    = ORDER_W'(side_r) * ORDER_W'(side_r);

  // Pick the state the step starts from and form its result
  always_comb begin
    cur     = restart ? start_state(side_r, mode_r) : st_r;
    order   = cur.count + ORDER_W'(1);
    is_last = (order >= total);
  end

  // Advance to the next cell of the current mode
  always_comb begin
    adv       = cur;
    adv.count = order;
    diag      = $signed({2'b00, cur.row}) - $signed({2'b00, cur.col});
    diag_m1   = diag - 8'sd1;
    side_m1   = $signed({1'b0, side_r}) - 8'sd1;
    diag_tmp  = '0;
    case (mode_r)
      MODE_COLUMN: begin
        if (cur.row < last_idx) begin
          adv.row = cur.row + ROW_W'(1);
        end else begin
          adv.row = '0;
          adv.col = cur.col + ROW_W'(1);
        end
      end
      MODE_SERPENTINE: begin
        if (!cur.col[0]) begin
          if (cur.row < last_idx) adv.row = cur.row + ROW_W'(1);
          else                    adv.col = cur.col + ROW_W'(1);
        end else begin
          if (cur.row > '0) adv.row = cur.row - ROW_W'(1);
          else              adv.col = cur.col + ROW_W'(1);
        end
      end
      MODE_ZIGZAG: begin
        if (cur.dir == DIAG_UP_LEFT) begin
          if (cur.row > '0 && cur.col > '0) begin
            adv.row = cur.row - ROW_W'(1);
            adv.col = cur.col - ROW_W'(1);
          end else begin
            // enter the next diagonal at its upper-left end
            adv.dir = DIAG_DOWN_RIGHT;
            if (!diag_m1[ROW_W+1]) begin
              adv.row = diag_m1[ROW_W-1:0];
              adv.col = '0;
            end else begin
              diag_tmp = -diag_m1;
              adv.row  = '0;
              adv.col  = diag_tmp[ROW_W-1:0];
            end
          end
        end else begin
          if (cur.row < last_idx && cur.col < last_idx) begin
            adv.row = cur.row + ROW_W'(1);
            adv.col = cur.col + ROW_W'(1);
          end else begin
            // enter the next diagonal at its lower-right end
            adv.dir = DIAG_UP_LEFT;
            if (!diag_m1[ROW_W+1]) begin
              diag_tmp = side_m1 - diag_m1;
              adv.row  = last_idx;
              adv.col  = diag_tmp[ROW_W-1:0];
            end else begin
              diag_tmp = side_m1 + diag_m1;
              adv.row  = diag_tmp[ROW_W-1:0];
              adv.col  = last_idx;
            end
          end
        end
      end
      default: begin
        case (spiral_dir_t'(cur.dir))
          DIR_DOWN: begin
            if (cur.row < cur.bottom) begin
              adv.row = cur.row + ROW_W'(1);
            end else begin
              adv.left = cur.left + ROW_W'(1);
              adv.dir  = DIR_RIGHT;
              adv.col  = cur.left + ROW_W'(1);
            end
          end
          DIR_RIGHT: begin
            if (cur.col < cur.right) begin
              adv.col = cur.col + ROW_W'(1);
            end else begin
              adv.bottom = cur.bottom - ROW_W'(1);
              adv.dir    = DIR_UP;
              adv.row    = cur.bottom - ROW_W'(1);
            end
          end
          DIR_UP: begin
            if (cur.row > cur.top) begin
              adv.row = cur.row - ROW_W'(1);
            end else begin
              adv.right = cur.right - ROW_W'(1);
              adv.dir   = DIR_LEFT;
              adv.col   = cur.right - ROW_W'(1);
            end
          end
          default: begin
            if (cur.col > cur.left) begin
              adv.col = cur.col - ROW_W'(1);
            end else begin
              adv.top = cur.top + ROW_W'(1);
              adv.dir = DIR_DOWN;
              adv.row = cur.top + ROW_W'(1);
            end
          end
        endcase
      end
    endcase
  end

  // Next values of configuration, scan state and output register
  always_comb begin
    side_nxt      = side_r;
    mode_nxt      = mode_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_order_nxt = out_order_r;
    out_last_nxt  = out_last_r;

    // drop the result once it is taken, load a new one on an input transfer
    if (out_tready) out_valid_nxt = 1'b0;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = cur.row;
      out_col_nxt   = cur.col;
      out_order_nxt = order;
      out_last_nxt  = is_last;
      st_nxt        = is_last ? start_state(side_r, mode_r) : adv;
    end

    // a write to the side or mode register restarts the scan under the new setting
    if (cfg_wr_en) begin
      if (cfg_index == CFG_IDX_SIDE) begin
        side_nxt = clamp_side(cfg_data);
        st_nxt   = start_state(clamp_side(cfg_data), mode_r);
      end else if (cfg_index == CFG_IDX_MODE) begin
        mode_nxt = scan_mode_t'(cfg_data[1:0]);
        st_nxt   = start_state(side_r, scan_mode_t'(cfg_data[1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SIDE_RESET;
      mode_r      <= MODE_COLUMN;
      st_r        <= start_state(SIDE_RESET, MODE_COLUMN);
      out_valid_r <= 1'b0;
    end else begin
      side_r      <= side_nxt;
      mode_r      <= mode_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload holds without reset
  always_ff @(posedge clk) begin
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_order_r <= out_order_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_order_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  // The scan position always lies inside the grid
  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.row < last_idx + ROW_W'(1) || side_r == SIDE_W'(MAX_SIDE))
    && (st_r.col < last_idx + ROW_W'(1) || side_r == SIDE_W'(MAX_SIDE)))
    else $error("scan position outside the grid");

  // Cells emitted so far stay below the cell count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count < total)
    else $error("scan count reached the cell count");

  // A restart transfer yields order 1 in the next cycle
  a_restart_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && restart |=> out_valid_r && out_order_r == ORDER_W'(1))
    else $error("restart did not emit the first cell");

  // A transfer on a single-cell grid is always the last cell
  a_single_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && side_r == SIDE_W'(1) && !cfg_wr_en |=> out_last_r)
    else $error("single-cell grid result not marked last");

endmodule
